// ----- rtl/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher package
// Shared types, register indexes, rotor wiring tables and modulo-25 helpers.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned Letters = 25;

  typedef enum logic [1:0] {
    REG_KEY_RIGHT  = 2'd0,
    REG_KEY_CENTER = 2'd1,
    REG_KEY_LEFT   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_LETTER,
    KIND_SPACE,
    KIND_BAD
  } kind_e;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NONE  = 8'h00;
  localparam logic [4:0] IDX_V      = 5'd21;
  localparam logic [4:0] IDX_MIRROR = 5'd12;
  localparam logic [4:0] REFL_SHIFT = 5'd13;
  localparam logic [1:0] CENTER_LAST = 2'd2;
  localparam logic [3:0] LEFT_LAST   = 4'd10;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       bad_char;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] x;
    logic [4:0] rs;
    logic [4:0] cs;
    logic [4:0] ls;
  } job_t;

  typedef logic [4:0] tab_t [Letters];

  localparam tab_t WIRE_R = '{5'd0, 5'd15, 5'd3, 5'd4, 5'd5, 5'd10, 5'd22, 5'd23, 5'd6,
    5'd7, 5'd17, 5'd18, 5'd19, 5'd2, 5'd8, 5'd1, 5'd11, 5'd12, 5'd13, 5'd14, 5'd20,
    5'd21, 5'd9, 5'd16, 5'd24};
  localparam tab_t INV_R = '{5'd0, 5'd15, 5'd13, 5'd2, 5'd3, 5'd4, 5'd8, 5'd9, 5'd14,
    5'd22, 5'd5, 5'd16, 5'd17, 5'd18, 5'd19, 5'd1, 5'd23, 5'd10, 5'd11, 5'd12, 5'd20,
    5'd21, 5'd6, 5'd7, 5'd24};
  localparam tab_t WIRE_C = '{5'd2, 5'd3, 5'd4, 5'd5, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd16, 5'd6, 5'd17, 5'd18, 5'd0, 5'd7, 5'd1, 5'd23, 5'd24,
    5'd19, 5'd20, 5'd21, 5'd22};
  localparam tab_t INV_C = '{5'd16, 5'd18, 5'd0, 5'd1, 5'd2, 5'd3, 5'd13, 5'd17, 5'd4,
    5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd21, 5'd22,
    5'd23, 5'd24, 5'd19, 5'd20};
  localparam tab_t WIRE_L = '{5'd7, 5'd16, 5'd17, 5'd18, 5'd12, 5'd13, 5'd0, 5'd22,
    5'd23, 5'd10, 5'd11, 5'd3, 5'd14, 5'd21, 5'd24, 5'd15, 5'd1, 5'd2, 5'd19, 5'd20,
    5'd8, 5'd9, 5'd4, 5'd5, 5'd6};
  localparam tab_t INV_L = '{5'd6, 5'd16, 5'd17, 5'd11, 5'd22, 5'd23, 5'd24, 5'd0,
    5'd20, 5'd21, 5'd9, 5'd10, 5'd4, 5'd5, 5'd12, 5'd15, 5'd1, 5'd2, 5'd3, 5'd18,
    5'd19, 5'd13, 5'd7, 5'd8, 5'd14};

  function automatic logic [4:0] add25(logic [4:0] a, logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(Letters)) s = s - 6'(Letters);
    return s[4:0];
  endfunction

  function automatic logic [4:0] sub25(logic [4:0] a, logic [4:0] b);
    logic [5:0] d;
    if (a >= b) d = {1'b0, a} - {1'b0, b};
    else d = {1'b0, a} + 6'(Letters) - {1'b0, b};
    return d[4:0];
  endfunction

  function automatic logic [4:0] mod25(logic [4:0] a);
    return (a >= 5'(Letters)) ? a - 5'(Letters) : a;
  endfunction

  function automatic logic [4:0] reflect(logic [4:0] i);
    logic [4:0] r;
    if (i < IDX_MIRROR) r = i + REFL_SHIFT;
    else if (i == IDX_MIRROR) r = i;
    else r = i - REFL_SHIFT;
    return r;
  endfunction

  function automatic logic [7:0] kb_char(logic [4:0] i);
    return (i >= IDX_V) ? CHAR_B + {3'd0, i} : CHAR_A + {3'd0, i};
  endfunction

endpackage

// ----- rtl/rsc_front.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher front end
// Classifies each character, steps the rotors and issues a job to the queue.
// ----------------------------------------------------------------------------
module rsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rsc_pkg::in_item_t in_item_i,
  output logic              push_o,
  output rsc_pkg::job_t     job_o,
  input  logic              full_i
);
  import rsc_pkg::*;

  logic [4:0] rs_q, rs_d, cs_q, cs_d, ls_q, ls_d;
  logic [1:0] mod3_q, mod3_d;
  logic [3:0] mod11_q, mod11_d;
  logic       accept;
  logic       is_letter;
  logic [7:0] c;
  logic [7:0] ofs;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign c          = in_item_i.char_in;
  assign is_letter  = (c >= CHAR_A) && (c <= CHAR_Z) && (c != CHAR_V);
  assign ofs        = (c > CHAR_V) ? c - CHAR_B : c - CHAR_A;

  always_comb begin
    rs_d    = rs_q;
    cs_d    = cs_q;
    ls_d    = ls_q;
    mod3_d  = mod3_q;
    mod11_d = mod11_q;
    if (is_letter) begin
      rs_d    = add25(rs_q, 5'd1);
      cs_d    = (mod3_q == 2'd0) ? add25(cs_q, 5'd1) : cs_q;
      ls_d    = (mod11_q == 4'd0) ? add25(ls_q, 5'd1) : ls_q;
      mod3_d  = (mod3_q == CENTER_LAST) ? 2'd0 : mod3_q + 2'd1;
      mod11_d = (mod11_q == LEFT_LAST) ? 4'd0 : mod11_q + 4'd1;
    end
  end

  always_comb begin
    job_o.x  = ofs[4:0];
    job_o.rs = rs_d;
    job_o.cs = cs_d;
    job_o.ls = ls_d;
    if (c == CHAR_SPACE) job_o.kind = KIND_SPACE;
    else if (is_letter) job_o.kind = KIND_LETTER;
    else job_o.kind = KIND_BAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q    <= '0;
      cs_q    <= '0;
      ls_q    <= '0;
      mod3_q  <= '0;
      mod11_q <= '0;
    end else if (accept) begin
      if (in_item_i.end_of_message) begin
        rs_q    <= '0;
        cs_q    <= '0;
        ls_q    <= '0;
        mod3_q  <= '0;
        mod11_q <= '0;
      end else begin
        rs_q    <= rs_d;
        cs_q    <= cs_d;
        ls_q    <= ls_d;
        mod3_q  <= mod3_d;
        mod11_q <= mod11_d;
      end
    end
  end

endmodule

// ----- rtl/rsc_queue.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher job queue
// Two-entry queue that decouples the front end from the cipher pipeline.
// ----------------------------------------------------------------------------
module rsc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rsc_pkg::job_t job_o
);
  import rsc_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- rtl/rsc_back.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher back end
// Six-stage rotor pipeline with key registers and the result register.
// ----------------------------------------------------------------------------
module rsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               head_valid_i,
  input  rsc_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsc_pkg::out_item_t out_item_o
);
  import rsc_pkg::*;

  localparam int unsigned Stages = 6;

  logic [4:0] kr_q, kc_q, kl_q;
  job_t       st_q [Stages];
  job_t       st_d [Stages];
  job_t       src [Stages];
  logic [Stages-1:0] v_q, free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_q <= '0;
      kc_q <= '0;
      kl_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_RIGHT:  kr_q <= mod25(cfg_data_i);
        REG_KEY_CENTER: kc_q <= mod25(cfg_data_i);
        REG_KEY_LEFT:   kl_q <= mod25(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    free[Stages-1] = !v_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) free[k] = !v_q[k] || free[k+1];
  end

  assign pop_o = head_valid_i && free[0];

  always_comb begin
    src[0] = head_i;
    for (int k = 1; k < Stages; k++) src[k] = st_q[k-1];
    st_d = src;
    st_d[0].x = sub25(WIRE_R[add25(src[0].x, src[0].rs)], add25(kr_q, src[0].rs));
    st_d[1].x = sub25(WIRE_C[add25(src[1].x, src[1].cs)], add25(kc_q, src[1].cs));
    st_d[2].x = sub25(WIRE_L[add25(src[2].x, src[2].ls)], add25(kl_q, src[2].ls));
    st_d[3].x = sub25(INV_L[add25(reflect(src[3].x), add25(kl_q, src[3].ls))], src[3].ls);
    st_d[4].x = sub25(INV_C[add25(src[4].x, add25(kc_q, src[4].cs))], src[4].cs);
    st_d[5].x = sub25(INV_R[add25(src[5].x, add25(kr_q, src[5].rs))], src[5].rs);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (free[k]) st_q[k] <= st_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (free[0]) v_q[0] <= head_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (free[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[Stages-1];

  always_comb begin
    case (st_q[Stages-1].kind)
      KIND_LETTER: begin
        out_item_o.char_out = kb_char(st_q[Stages-1].x);
        out_item_o.bad_char = 1'b0;
      end
      KIND_SPACE: begin
        out_item_o.char_out = CHAR_SPACE;
        out_item_o.bad_char = 1'b0;
      end
      default: begin
        out_item_o.char_out = CHAR_NONE;
        out_item_o.bad_char = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/rotor_substitution_cipher.sv -----
// ----------------------------------------------------------------------------
// Rotor substitution cipher
// Three-rotor reflecting cipher over a 25-letter keyboard, one character a word.
// ----------------------------------------------------------------------------
//  Channel | Signals                                  | Direction
//  in      | in_valid_i, in_ready_o, in_item_i        | character in
//  out     | out_valid_o, out_ready_i, out_item_o     | cipher character out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | key letter writes
//
// One word is accepted per cycle while in_ready_o is high; an accepted word waits
// in the job queue and then passes through the five rotor stages ahead of the
// last stage, which is the output register.
// Reset puts the keys, rotor steps and turn counters at zero and empties
// the pipeline. A stalled output fills the pipeline, then the two-entry queue,
// and only then drops in_ready_o.
module rotor_substitution_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rsc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsc_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [4:0]         cfg_data_i
);
  import rsc_pkg::*;

  logic push, full, pop, head_valid;
  job_t job, head;

  rsc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .push_o (push),
    .job_o  (job),
    .full_i (full)
  );

  rsc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head)
  );

  rsc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

endmodule

// ----- rtl/rsc_checker.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rsc_pkg::out_item_t out_item_o
);
  import rsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Output word changed while stalled.");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_char |-> out_item_o.char_out == CHAR_NONE)
    else $error("Bad character result is not zero.");

  a_good_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.bad_char |->
      out_item_o.char_out == CHAR_SPACE ||
      (out_item_o.char_out >= CHAR_A && out_item_o.char_out <= CHAR_Z &&
       out_item_o.char_out != CHAR_V))
    else $error("Result is not a keyboard letter or space.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("Output valid during reset.");

endmodule

bind rotor_substitution_cipher rsc_checker u_rsc_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .out_item_o
);

// ----- tb/rotor_cipher_check_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotor cipher scoreboard
// Tracks the rotor positions and keys of the three-rotor cipher, works out the
// expected cipher word for every accepted input word, and checks each result
// word against the oldest expected one.
// ----------------------------------------------------------------------------
package rotor_cipher_check_pkg;

  import rsc_pkg::*;

  localparam int KB_SIZE      = 25;
  localparam int ROTORS       = 3;
  localparam int CENTER_EVERY = 3;
  localparam int LEFT_EVERY   = 11;
  localparam int TURN_WRAP    = 33;
  localparam int V_SLOT       = 21;
  localparam int MIRROR_SLOT  = 12;
  localparam int HALF_TURN    = 13;

  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_V     = 8'h56;
  localparam logic [7:0] ASCII_Z     = 8'h5A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] NO_CHAR     = 8'h00;

  class cipher_tracker;
    int wiring[ROTORS][KB_SIZE];
    int inverse[ROTORS][KB_SIZE];
    int key[ROTORS];
    int steps[ROTORS];
    int turns;
    out_item_t expected_cipher[$];
    int mismatches;
    int checked;

    function new();
      int r;
      int i;
      wiring[0] = '{0, 15, 3, 4, 5, 10, 22, 23, 6, 7, 17, 18, 19, 2, 8, 1, 11, 12, 13,
                    14, 20, 21, 9, 16, 24};
      wiring[1] = '{2, 3, 4, 5, 8, 9, 10, 11, 12, 13, 14, 15, 16, 6, 17, 18, 0, 7, 1,
                    23, 24, 19, 20, 21, 22};
      wiring[2] = '{7, 16, 17, 18, 12, 13, 0, 22, 23, 10, 11, 3, 14, 21, 24, 15, 1, 2,
                    19, 20, 8, 9, 4, 5, 6};
      for (r = 0; r < ROTORS; r++) begin
        for (i = 0; i < KB_SIZE; i++) begin
          inverse[r][wiring[r][i]] = i;
        end
      end
      key = '{0, 0, 0};
      steps = '{0, 0, 0};
      turns = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_key(reg_idx_e which, logic [4:0] value);
      key[int'(which)] = int'(value) % KB_SIZE;
    endfunction

    function int pending();
      return expected_cipher.size();
    endfunction

    function out_item_t encipher(in_item_t w);
      out_item_t ct;
      int x;
      int r;
      ct.char_out = NO_CHAR;
      ct.bad_char = 1'b0;
      if (w.char_in == ASCII_SPACE) begin
        ct.char_out = ASCII_SPACE;
      end else if (w.char_in < ASCII_A || w.char_in > ASCII_Z || w.char_in == ASCII_V) begin
        ct.bad_char = 1'b1;
      end else begin
        x = int'(w.char_in) - int'(ASCII_A) - ((w.char_in > ASCII_V) ? 1 : 0);
        steps[0] = (steps[0] + 1) % KB_SIZE;
        if (turns % CENTER_EVERY == 0) steps[1] = (steps[1] + 1) % KB_SIZE;
        if (turns % LEFT_EVERY == 0) steps[2] = (steps[2] + 1) % KB_SIZE;
        for (r = 0; r < ROTORS; r++) begin
          x = (wiring[r][(x + steps[r]) % KB_SIZE] + 2 * KB_SIZE - key[r] - steps[r])
              % KB_SIZE;
        end
        if (x < MIRROR_SLOT) x = x + HALF_TURN;
        else if (x > MIRROR_SLOT) x = x - HALF_TURN;
        for (r = ROTORS - 1; r >= 0; r--) begin
          x = (inverse[r][(x + key[r] + steps[r]) % KB_SIZE] + KB_SIZE - steps[r]) % KB_SIZE;
        end
        ct.char_out = 8'(int'(ASCII_A) + x + ((x >= V_SLOT) ? 1 : 0));
        turns = (turns + 1) % TURN_WRAP;
      end
      if (w.end_of_message) begin
        steps = '{0, 0, 0};
        turns = 0;
      end
      return ct;
    endfunction

    function void note_plain(in_item_t w);
      out_item_t ct;
      ct = encipher(w);
      expected_cipher.insert(expected_cipher.size(), ct);
    endfunction

    function void check_cipher(out_item_t got);
      out_item_t want;
      if (expected_cipher.size() == 0) begin
        $display("%t: result word with nothing expected: char_out %h bad_char %b",
                 $time, got.char_out, got.bad_char);
        mismatches++;
        return;
      end
      want = expected_cipher.pop_front();
      checked++;
      if (got.char_out !== want.char_out) begin
        $display("%t: char_out expected %h actual %h", $time, want.char_out, got.char_out);
        mismatches++;
      end
      if (got.bad_char !== want.bad_char) begin
        $display("%t: bad_char expected %b actual %b", $time, want.bad_char, got.bad_char);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/rotor_substitution_cipher_test.sv -----
// ----------------------------------------------------------------------------
// Rotor substitution cipher testbench
// Drives ASCII words through the cipher under several key settings and
// handshake mixes, including a long output hold-off, and checks every result
// word against a scoreboard that tracks the rotor positions.
// ----------------------------------------------------------------------------
module rotor_substitution_cipher_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;
  import rotor_cipher_check_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEGMENTS     = 8;
  localparam int SEGMENT_WORDS = 160;

  localparam logic [7:0] CH_U       = 8'h55;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  logic      clk_i;
  logic      rst_ni = 1'b1;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [4:0] cfg_data_i = '0;

  cipher_tracker tracker = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int words_sent = 0;
  int key_loads = 0;

  rotor_substitution_cipher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.note_plain(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_cipher(out_item_o);
  end

  // The hold-off is counted here so the sender keeps offering words meanwhile.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_word(logic [7:0] c, logic eom);
    in_item_t w;
    w.char_in = c;
    w.end_of_message = eom;
    return w;
  endfunction

  function automatic in_item_t random_word(logic eom);
    int pick;
    int slot;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 75) begin
      slot = $urandom_range(KB_SIZE - 1);
      c = 8'(int'(ASCII_A) + slot + ((slot >= V_SLOT) ? 1 : 0));
    end else if (pick < 87) begin
      c = ASCII_SPACE;
    end else begin
      c = 8'($urandom_range(255));
    end
    return make_word(c, eom);
  endfunction

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic load_keys(input logic [4:0] kr, input logic [4:0] kc, input logic [4:0] kl);
    reg_idx_e regs[3];
    logic [4:0] vals[3];
    int k;
    regs = '{REG_KEY_RIGHT, REG_KEY_CENTER, REG_KEY_LEFT};
    vals = '{kr, kc, kl};
    for (k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      tracker.set_key(regs[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
    key_loads++;
  endtask

  task automatic run_directed();
    int k;
    send_word(make_word(ASCII_A, 1'b0));
    send_word(make_word(ASCII_Z, 1'b0));
    send_word(make_word(ASCII_V, 1'b0));
    send_word(make_word(ASCII_SPACE, 1'b0));
    send_word(make_word(NO_CHAR, 1'b0));
    send_word(make_word(CH_TOP, 1'b0));
    send_word(make_word(CH_LOWER_A, 1'b0));
    send_word(make_word(CH_AT, 1'b0));
    send_word(make_word(CH_BRACKET, 1'b0));
    send_word(make_word(CH_U, 1'b0));
    send_word(make_word(CH_W, 1'b1));
    for (k = 0; k < 8; k++) send_word(make_word(ASCII_A, 1'b0));
    send_word(make_word(ASCII_SPACE, 1'b1));
    for (k = 0; k < 3; k++) send_word(make_word(ASCII_Z, 1'b0));
    send_word(make_word(ASCII_V, 1'b1));
    send_word(make_word(ASCII_Z, 1'b1));
  endtask

  task automatic send_segment(input int words);
    int sent;
    int len;
    int j;
    logic eom;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(100, 280) : $urandom_range(1, 40);
      for (j = 0; j < len && sent < words; j++) begin
        eom = (j == len - 1) || ($urandom_range(59) == 0);
        send_word(random_word(eom));
        sent++;
        if (sent == words / 2) drain();
      end
    end
  endtask

  initial begin
    int seg;
    int k;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();

    load_keys(5'd24, 5'd24, 5'd24);
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) send_word(random_word($urandom_range(29) == 0));
    settle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (seg)
        0: load_keys(5'd0, 5'd0, 5'd0);
        1: load_keys(5'd24, 5'd24, 5'd24);
        2: load_keys(5'd25, 5'd31, 5'd28);
        3: load_keys(5'd31, 5'd0, 5'd24);
        default: load_keys(5'($urandom_range(31)), 5'($urandom_range(31)),
                           5'($urandom_range(31)));
      endcase
      send_segment(SEGMENT_WORDS);
      settle();
    end

    $display("Sent %0d words (letters, spaces, bad bytes) over %0d key settings,",
             words_sent, key_loads);
    $display("four handshake mixes and a long output hold-off; %0d results checked.",
             tracker.checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rsc_pkg.sv
rtl/rsc_front.sv
rtl/rsc_queue.sv
rtl/rsc_back.sv
rtl/rotor_substitution_cipher.sv
rtl/rsc_checker.sv
tb/rotor_cipher_check_pkg.sv
tb/rotor_substitution_cipher_test.sv
